// File: hw/rtl/assert_macros.svh
// Concurrent assertion helpers: clocked, disabled while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned PartW = 15;

  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;

  // one entry per byte that yields results: one or two code points
  typedef struct packed {
    logic [CpW-1:0] cp0;
    logic [CpW-1:0] cp1;
    logic           two;
    logic           fin;
  } rec_t;

endpackage

// File: hw/rtl/u8d_front.sv
module u8d_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,
  input  logic               s_axis_tlast_i,
  input  logic               full_i,
  output logic               push_o,
  output u8d_pkg::rec_t      rec_o,
  output logic               busy_o
);

  logic [1:0]                   pend_q, pend_d;
  logic [u8d_pkg::PartW-1:0]    part_q, part_d;
  logic                         accept;

  logic                         lead_emit;
  logic [u8d_pkg::CpW-1:0]      lead_cp;
  logic [1:0]                   lead_pend;
  logic [u8d_pkg::PartW-1:0]    lead_part;

  logic [1:0]                   cnt;
  logic [u8d_pkg::CpW-1:0]      cp0, cp1;
  logic [u8d_pkg::CpW-1:0]      cont_v;
  logic                         use_lead;

  assign s_axis_tready_o = !full_i;
  assign accept          = s_axis_tvalid_i && !full_i;
  assign busy_o          = (pend_q != 2'd0);
  assign cont_v          = {part_q, s_axis_tdata_i[5:0]};

  always_comb begin
    lead_emit = 1'b0;
    lead_cp   = u8d_pkg::Replacement;
    lead_pend = 2'd0;
    lead_part = '0;
    if (!s_axis_tdata_i[7]) begin
      lead_emit = 1'b1;
      lead_cp   = {13'd0, s_axis_tdata_i};
    end else if (s_axis_tdata_i[7:5] == 3'b110) begin
      lead_pend = 2'd1;
      lead_part = {10'd0, s_axis_tdata_i[4:0]};
    end else if (s_axis_tdata_i[7:4] == 4'b1110) begin
      lead_pend = 2'd2;
      lead_part = {11'd0, s_axis_tdata_i[3:0]};
    end else if (s_axis_tdata_i[7:3] == 5'b11110) begin
      lead_pend = 2'd3;
      lead_part = {12'd0, s_axis_tdata_i[2:0]};
    end else begin
      lead_emit = 1'b1;
    end
  end

  always_comb begin
    cnt      = 2'd0;
    cp0      = u8d_pkg::Replacement;
    cp1      = u8d_pkg::Replacement;
    pend_d   = pend_q;
    part_d   = part_q;
    use_lead = 1'b1;
    if (pend_q != 2'd0) begin
      if (s_axis_tdata_i[7:6] == 2'b10) begin
        use_lead = 1'b0;
        if (pend_q == 2'd1) begin
          cp0    = cont_v;
          cnt    = 2'd1;
          pend_d = 2'd0;
          part_d = '0;
        end else begin
          pend_d = pend_q - 2'd1;
          part_d = cont_v[u8d_pkg::PartW-1:0];
        end
      end else begin
        cnt = 2'd1;
      end
    end
    if (use_lead) begin
      pend_d = lead_pend;
      part_d = lead_part;
      if (lead_emit) begin
        if (cnt == 2'd0) begin
          cp0 = lead_cp;
        end else begin
          cp1 = lead_cp;
        end
        cnt = cnt + 2'd1;
      end
    end
    // close a sequence cut off by the end of text
    if (s_axis_tlast_i && (pend_d != 2'd0)) begin
      cnt    = cnt + 2'd1;
      pend_d = 2'd0;
      part_d = '0;
    end
  end

  assign push_o    = accept && (cnt != 2'd0);
  assign rec_o.cp0 = cp0;
  assign rec_o.cp1 = cp1;
  assign rec_o.two = (cnt == 2'd2);
  assign rec_o.fin = s_axis_tlast_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      part_q <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

endmodule

// File: hw/rtl/u8d_fifo.sv
module u8d_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u8d_pkg::rec_t rec_i,
  input  logic          pop_i,
  output u8d_pkg::rec_t rec_o,
  output logic          valid_o,
  output logic          full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u8d_pkg::rec_t     mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: hw/rtl/u8d_back.sv
module u8d_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  u8d_pkg::rec_t head_i,
  input  logic          head_valid_i,
  output logic          pop_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [23:0]   m_axis_tdata_o,
  output logic          m_axis_tlast_o,
  output logic          m_axis_tuser_o
);

  logic                      out_valid_q, out_valid_d;
  logic                      second_q, second_d;
  logic [u8d_pkg::CpW-1:0]   cp_q, cp_d;
  logic                      last_q, last_d;
  logic                      done_q, done_d;
  logic                      load;

  assign load = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    second_d    = second_q;
    cp_d        = cp_q;
    last_d      = last_q;
    done_d      = done_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_i.two && !second_q) begin
          cp_d     = head_i.cp0;
          last_d   = 1'b0;
          done_d   = 1'b0;
          second_d = 1'b1;
        end else begin
          cp_d     = second_q ? head_i.cp1 : head_i.cp0;
          last_d   = 1'b1;
          done_d   = head_i.fin;
          second_d = 1'b0;
          pop_o    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q   <= cp_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, cp_q};
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = done_q;

endmodule

// File: hw/rtl/utf8_stream_decoder_top.sv
// channel  dir  tdata                       tlast         tuser
// s_axis   in   [7:0] data_byte             final_byte    -
// m_axis   out  [20:0] code_point, pad to 24 last_of_run  text_done
//
// Takes one byte per cycle while the queue is not full; the front decoder state
// updates in the accept cycle. A byte yields zero, one or two code points; the
// output register sends one beat per cycle while m_axis_tready is high, so a
// two-result byte takes two beats. Beats pass the queue, then the output register.
// Reset clears decoder state, queue pointers and the output valid.
// Input stalls only when the QueueDepth-entry queue is full.
`include "assert_macros.svh"

module utf8_stream_decoder_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_axis_tlast,   // last_of_run
  output logic        m_axis_tuser    // text_done
);

  u8d_pkg::rec_t push_rec, head_rec;
  logic          push, pop, full, head_valid, busy;

  u8d_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .full_i          (full),
    .push_o          (push),
    .rec_o           (push_rec),
    .busy_o          (busy)
  );

  u8d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .rec_o   (head_rec),
    .valid_o (head_valid),
    .full_o  (full)
  );

  u8d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_rec),
    .head_valid_i    (head_valid),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  `ASSERT_NEXT(a_fin_idle, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast, !busy)
  `ASSERT_IMPLIES(a_done_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `ASSERT_NEXT(a_pair_cont, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

endmodule

// File: tb/utf8_decoder_checker.sv
`timescale 1ns / 100ps

module utf8_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // final_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
  input  logic        m_axis_tlast,   // last_of_run
  input  logic        m_axis_tuser,   // text_done
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Tag  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Tag  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Tag  = 8'hF0;
  localparam logic [7:0] AsciiTop  = 8'h80;

  typedef struct packed {
    logic [u8d_pkg::CpW-1:0] cp;
    logic                    last;
    logic                    done;
  } cp_beat_t;

  cp_beat_t                  expected_cps[$];
  logic [u8d_pkg::PartW-1:0] partial_q;
  logic [1:0]                due_q;
  logic [u8d_pkg::CpW-1:0]   emitted[2];
  int                        n_emitted;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic emit_cp(input logic [u8d_pkg::CpW-1:0] cp);
    if (n_emitted < 2) begin
      emitted[n_emitted] = cp;
      n_emitted++;
    end
  endtask

  task automatic start_sequence(input logic [7:0] b);
    if (b < AsciiTop) begin
      emit_cp({{(u8d_pkg::CpW-8){1'b0}}, b});
    end else if ((b & Lead2Mask) == Lead2Tag) begin
      partial_q = {{(u8d_pkg::PartW-5){1'b0}}, b[4:0]};
      due_q = 2'd1;
    end else if ((b & Lead3Mask) == Lead3Tag) begin
      partial_q = {{(u8d_pkg::PartW-4){1'b0}}, b[3:0]};
      due_q = 2'd2;
    end else if ((b & Lead4Mask) == Lead4Tag) begin
      partial_q = {{(u8d_pkg::PartW-3){1'b0}}, b[2:0]};
      due_q = 2'd3;
    end else begin
      emit_cp(u8d_pkg::Replacement);
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic fin);
    logic [u8d_pkg::CpW-1:0] v;
    n_emitted = 0;
    if (due_q != 2'd0) begin
      if ((b & ContMask) == ContTag) begin
        v = {partial_q, b[5:0]};
        due_q = due_q - 2'd1;
        if (due_q == 2'd0) begin
          emit_cp(v);
          partial_q = '0;
        end else begin
          partial_q = v[u8d_pkg::PartW-1:0];
        end
      end else begin
        emit_cp(u8d_pkg::Replacement);
        due_q = 2'd0;
        partial_q = '0;
        start_sequence(b);
      end
    end else begin
      start_sequence(b);
    end
    if (fin && due_q != 2'd0) begin
      emit_cp(u8d_pkg::Replacement);
      due_q = 2'd0;
      partial_q = '0;
    end
    for (int k = 0; k < n_emitted; k++) begin
      expected_cps.push_back('{cp: emitted[k], last: (k == n_emitted - 1),
                               done: (k == n_emitted - 1) && fin});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cp_beat_t exp_beat;
    if (!rst_ni) begin
      expected_cps.delete();
      partial_q = '0;
      due_q = 2'd0;
      fail_count_o = 0;
      checked_o = 0;
      pending_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_byte(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cps.size() == 0) begin
          report_mismatch($sformatf("unexpected beat cp=%06h",
                                    m_axis_tdata[u8d_pkg::CpW-1:0]));
        end else begin
          exp_beat = expected_cps.pop_front();
          checked_o++;
          if (m_axis_tdata[u8d_pkg::CpW-1:0] !== exp_beat.cp)
            report_mismatch($sformatf("code_point %06h, want %06h",
                                      m_axis_tdata[u8d_pkg::CpW-1:0], exp_beat.cp));
          if (m_axis_tdata[23:u8d_pkg::CpW] !== '0)
            report_mismatch($sformatf("pad bits %0b, want 0",
                                      m_axis_tdata[23:u8d_pkg::CpW]));
          if (m_axis_tlast !== exp_beat.last)
            report_mismatch($sformatf("last_of_run %0b, want %0b (cp %06h)",
                                      m_axis_tlast, exp_beat.last, exp_beat.cp));
          if (m_axis_tuser !== exp_beat.done)
            report_mismatch($sformatf("text_done %0b, want %0b (cp %06h)",
                                      m_axis_tuser, exp_beat.done, exp_beat.cp));
        end
      end
      pending_o <= expected_cps.size();
    end
  end

endmodule

// File: tb/utf8_stream_decoder_top_test.sv
`timescale 1ns / 100ps

module utf8_stream_decoder_top_test;

  localparam int RandomBytes = 1300;
  localparam int CycleLimit  = 200000;
  localparam int IdlePct     = 33;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  int   fail_count;
  int   pending_cps;
  int   checked_cps;
  int   cycle_count;
  int   bytes_sent;
  int   texts_sent;
  logic steady;
  logic [7:0] text_bytes[$];
  logic [8:0] directed_beats[26];

  utf8_stream_decoder_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  utf8_decoder_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending_cps),
    .checked_o     (checked_cps)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d code points outstanding",
               cycle_count, pending_cps);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // hold each beat until accepted; idle only before raising tvalid
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (fin) texts_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cps != 0);
  endtask

  task automatic gen_char();
    int pick;
    int len;
    int conts;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(1, 4);
    if (pick < 15) begin
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (pick >= 85 && len == 1) len = 2;
      case (len)
        1: text_bytes.push_back(8'($urandom_range(0, 127)));
        2: text_bytes.push_back({3'b110, 5'($urandom)});
        3: text_bytes.push_back({4'b1110, 4'($urandom)});
        default: text_bytes.push_back({5'b11110, 3'($urandom)});
      endcase
      conts = (pick >= 85) ? $urandom_range(0, len - 2) : len - 1;
      repeat (conts) text_bytes.push_back({2'b10, 6'($urandom)});
    end
  endtask

  initial begin
    logic mid_drained;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    steady        = 1'b0;
    mid_drained   = 1'b0;
    cycle_count   = 0;
    bytes_sent    = 0;
    texts_sent    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // {final_byte, data_byte}
    directed_beats = '{
      9'h000, 9'h07F, 9'h0C2, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
      9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
      9'h080, 9'h0F8, 9'h0FF, 9'h0C3, 9'h141, 9'h0E2, 9'h0F8,
      9'h0C3, 9'h1E2, 9'h0E2, 9'h182
    };
    foreach (directed_beats[i]) send_byte(directed_beats[i][7:0], directed_beats[i][8]);
    drain_results();

    while (bytes_sent < RandomBytes + 26) begin
      text_bytes.delete();
      repeat ($urandom_range(1, 10)) gen_char();
      steady = (bytes_sent > 600 && bytes_sent < 800);
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
      if (!mid_drained && bytes_sent > 400) begin
        mid_drained = 1'b1;
        drain_results();
      end
    end
    steady = 1'b0;
    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Decoded %0d bytes in %0d texts; %0d code points checked,",
             bytes_sent, texts_sent, checked_cps);
    $display("covering all lead forms, stray, broken and truncated sequences.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
